[hw/rtl/fbik_pkg.sv]
package fbik_pkg;

    // Internal word of the geometry datapath (wraps like 64-bit integer math)
    localparam int DW = 64;

    // CORDIC angle accumulator is Q16 degrees
    localparam int TAB_BITS     = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int ATAN_W       = 22;
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1
    };

    localparam int SQRT_STEPS = 32;
    localparam int NORM_K_MAX = 30;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_OFFSET   = 3'd4;

    localparam logic [7:0] RST_UPPER_LEN     = 8'd40;
    localparam logic [7:0] RST_LOWER_LEN     = 8'd24;
    localparam logic [7:0] RST_JOINT_SPACING = 8'd21;
    localparam logic [8:0] RST_FRONT_OFFSET  = 9'd135;
    localparam logic [8:0] RST_REAR_OFFSET   = 9'd135;

    // Servo limits and pulse mapping
    localparam int ANGLE_W     = 8;
    localparam int DEG_W       = 9;
    localparam int PULSE_W     = 12;
    localparam int MIN_DEG     = -90;
    localparam int MAX_DEG     = 90;
    localparam int MIN_PULSE   = 500;
    // (a + 90) * 2000 / 180 == ((a + 90) * PULSE_MUL) >> PULSE_SHIFT for a in -90..90
    localparam int PULSE_MUL   = 728200;
    localparam int PULSE_SHIFT = 16;

    typedef enum logic [1:0] {
        MS_PX,
        MS_PY,
        MS_L2S,
        MS_AN
    } t_msel;

    typedef struct packed {
        logic  load_in;
        logic  mul_go;
        t_msel msel;
        logic  mark_fail;
        logic  vec_a;
        logic  vec_b;
        logic  norm_step;
        logic  sqrt_init;
        logic  sqrt_step;
        logic  cord_init;
        logic  cord_step;
        logic  cord_end;
        logic  next_joint;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic fail;
        logic norm_more;
        logic sqrt_last;
        logic cord_last;
        logic phase_b;
        logic joint_rear;
    } t_stat;

endpackage

[hw/rtl/fbik_in_if.sv]
interface fbik_in_if #(
    parameter int COORD_WIDTH = 8
);
    logic                          valid;
    logic                          ready;
    logic                          is_left;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;

    modport source (output valid, output is_left, output x, output y, input ready);
    modport sink   (input valid, input is_left, input x, input y, output ready);
endinterface

[hw/rtl/fbik_out_if.sv]
interface fbik_out_if;
    logic              valid;
    logic              ready;
    logic              side;
    logic signed [7:0] front_deg;
    logic signed [7:0] rear_deg;
    logic [11:0]       front_pulse_us;
    logic [11:0]       rear_pulse_us;
    logic              unreachable;
    logic              front_rejected;
    logic              rear_rejected;

    modport source (
        output valid, output side, output front_deg, output rear_deg,
        output front_pulse_us, output rear_pulse_us, output unreachable,
        output front_rejected, output rear_rejected, input ready
    );
    modport sink (
        input valid, input side, input front_deg, input rear_deg,
        input front_pulse_us, input rear_pulse_us, input unreachable,
        input front_rejected, input rear_rejected, output ready
    );
endinterface

[hw/rtl/fbik_ctrl.sv]
module fbik_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fbik_pkg::t_cmd o_cmd,
    input  fbik_pkg::t_stat i_stat
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_JOINT = 15'b000000000000010,
        S_WPX   = 15'b000000000000100,
        S_WPY   = 15'b000000000001000,
        S_M2    = 15'b000000000010000,
        S_WM2   = 15'b000000000100000,
        S_NSQ   = 15'b000000001000000,
        S_WAN   = 15'b000000010000000,
        S_CHK   = 15'b000000100000000,
        S_NORM  = 15'b000001000000000,
        S_SQRT  = 15'b000010000000000,
        S_CINIT = 15'b000100000000000,
        S_CORD  = 15'b001000000000000,
        S_CEND  = 15'b010000000000000,
        S_FIN   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    fbik_pkg::t_cmd n_cmd;

    always_comb begin
        n_state     = r_state;
        n_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load_in = 1'b1;
                    n_state       = S_JOINT;
                end
            end
            S_JOINT: begin
                n_cmd.mul_go = 1'b1;
                n_cmd.msel   = fbik_pkg::MS_PX;
                n_state      = S_WPX;
            end
            S_WPX: begin
                if (i_stat.mul_done) begin
                    n_cmd.mul_go = 1'b1;
                    n_cmd.msel   = fbik_pkg::MS_PY;
                    n_state      = S_WPY;
                end
            end
            S_WPY: begin
                if (i_stat.mul_done) begin
                    n_state = S_M2;
                end
            end
            S_M2: begin
                n_cmd.mul_go = 1'b1;
                n_cmd.msel   = fbik_pkg::MS_L2S;
                n_state      = S_WM2;
            end
            S_WM2: begin
                if (i_stat.mul_done) begin
                    n_state = S_NSQ;
                end
            end
            S_NSQ: begin
                n_cmd.mul_go = 1'b1;
                n_cmd.msel   = fbik_pkg::MS_AN;
                n_state      = S_WAN;
            end
            S_WAN: begin
                if (i_stat.mul_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.fail) begin
                    n_cmd.mark_fail = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    n_cmd.vec_a = 1'b1;
                    n_state     = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.norm_more) begin
                    n_cmd.norm_step = 1'b1;
                end else begin
                    n_cmd.sqrt_init = 1'b1;
                    n_state         = S_SQRT;
                end
            end
            S_SQRT: begin
                n_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_last) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                n_cmd.cord_init = 1'b1;
                n_state         = S_CORD;
            end
            S_CORD: begin
                n_cmd.cord_step = 1'b1;
                if (i_stat.cord_last) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                n_cmd.cord_end = 1'b1;
                if (!i_stat.phase_b) begin
                    n_cmd.vec_b = 1'b1;
                    n_state     = S_NORM;
                end else if (i_stat.joint_rear) begin
                    n_state = S_FIN;
                end else begin
                    n_cmd.next_joint = 1'b1;
                    n_state          = S_JOINT;
                end
            end
            S_FIN: begin
                // wait for the output register to drain
                if (!r_out_valid || i_out_ready) begin
                    n_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

endmodule

[hw/rtl/fbik_dp.sv]
module fbik_dp #(
    parameter int COORD_WIDTH = 8,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbik_pkg::t_cmd                      i_cmd,
    output fbik_pkg::t_stat                     o_stat,
    input  logic                                i_is_left,
    input  logic signed [COORD_WIDTH-1:0]       i_x,
    input  logic signed [COORD_WIDTH-1:0]       i_y,
    input  logic                                i_cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbik_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_side,
    output logic signed [fbik_pkg::ANGLE_W-1:0] o_front_deg,
    output logic signed [fbik_pkg::ANGLE_W-1:0] o_rear_deg,
    output logic [fbik_pkg::PULSE_W-1:0]        o_front_pulse_us,
    output logic [fbik_pkg::PULSE_W-1:0]        o_rear_pulse_us,
    output logic                                o_unreachable,
    output logic                                o_front_rejected,
    output logic                                o_rear_rejected
);

    localparam int DW = fbik_pkg::DW;
    localparam int QW = FRAC_BITS + 9;
    localparam int AW = 11;
    localparam int AGW = fbik_pkg::ANGLE_W;
    localparam int DGW = fbik_pkg::DEG_W;
    localparam int PW = fbik_pkg::PULSE_W;
    localparam logic signed [DW-1:0] Z_MAX = DW'(180) << fbik_pkg::TAB_BITS;
    localparam logic signed [DW-1:0] Z_90  = DW'(90) << fbik_pkg::TAB_BITS;
    localparam logic signed [AW-1:0] A_MIN = AW'(fbik_pkg::MIN_DEG);
    localparam logic signed [AW-1:0] A_MAX = AW'(fbik_pkg::MAX_DEG);

    function automatic logic [PW-1:0] pulse_of(input logic signed [AGW-1:0] a);
        logic [8:0]  v;
        logic [28:0] p;
        v = {a[AGW-1], a} + 9'd90;
        p = 29'(v) * 29'(fbik_pkg::PULSE_MUL);
        return PW'((p >> fbik_pkg::PULSE_SHIFT) + 29'(fbik_pkg::MIN_PULSE));
    endfunction

    // configuration
    logic [7:0] r_upper, r_lower, r_spacing;
    logic [8:0] r_front_off, r_rear_off;

    // item
    logic                          r_side, r_joint, r_fail;
    logic signed [COORD_WIDTH-1:0] r_x, r_y;

    // geometry terms
    logic signed [DW-1:0] r_px, r_n;
    logic [DW-1:0]        r_s, r_ysq, r_m2, r_an2;

    // multiplier, 16 bits of b per pass
    logic [DW-1:0] r_ma, r_mb, r_acc;
    logic [1:0]    r_mcnt;
    logic          r_mbusy;
    fbik_pkg::t_msel r_msel;

    // vector angle unit
    logic signed [DW-1:0] r_vx, r_cx, r_cy, r_cz;
    logic [DW-1:0]        r_vysq, r_vm, r_sv, r_sr;
    logic [4:0]           r_k, r_it;
    logic                 r_phase;
    logic [QW-1:0]        r_qa;
    logic [DGW-1:0]       r_degf, r_degr;

    // held angles, indexed by side
    logic signed [AGW-1:0] r_hf [2];
    logic signed [AGW-1:0] r_hr [2];

    // result register
    logic                  r_o_side, r_o_unr, r_o_frej, r_o_rrej;
    logic signed [AGW-1:0] r_o_fa, r_o_ra;
    logic [PW-1:0]         r_o_fp, r_o_rp;

    logic signed [DW-1:0] w_xe, w_ye, w_px, w_n, w_an, w_dx, w_dy, w_zc;
    logic [15:0]          w_l2, w_u2;
    logic [DW-1:0]        w_part, w_mres, w_sbit, w_strial;
    logic [QW-1:0]        w_q;
    logic [DGW-1:0]       w_deg;
    logic                 w_mdone;
    logic signed [AW-1:0] w_dfe, w_dre, w_foe, w_roe, w_fa, w_ra;
    logic                 w_frej, w_rrej;
    logic signed [AGW-1:0] w_hf_new, w_hr_new;

    assign w_xe = {{(DW-COORD_WIDTH){r_x[COORD_WIDTH-1]}}, r_x};
    assign w_ye = {{(DW-COORD_WIDTH){r_y[COORD_WIDTH-1]}}, r_y};
    assign w_px = r_joint ? ({{(DW-8){1'b0}}, r_spacing} - w_xe) : w_xe;
    assign w_l2 = 16'(r_lower) * 16'(r_lower);
    assign w_u2 = 16'(r_upper) * 16'(r_upper);
    assign w_n  = {{(DW-16){1'b0}}, w_l2} + r_s - {{(DW-16){1'b0}}, w_u2};
    assign w_an = w_n[DW-1] ? -w_n : w_n;

    assign w_part  = r_ma * DW'(r_mb[15:0]);
    assign w_mres  = r_acc + w_part;
    assign w_mdone = r_mbusy && (r_mcnt == 2'd3);

    assign w_sbit   = DW'(1) << (6'd62 - {r_it, 1'b0});
    assign w_strial = r_sr + w_sbit;

    assign w_dx = r_cy >>> r_it;
    assign w_dy = r_cx >>> r_it;

    always_comb begin
        if (r_cz[DW-1]) begin
            w_zc = '0;
        end else if (r_cz > Z_MAX) begin
            w_zc = Z_MAX;
        end else begin
            w_zc = r_cz;
        end
    end
    assign w_q   = QW'(w_zc >> (fbik_pkg::TAB_BITS - FRAC_BITS));
    assign w_deg = DGW'((r_qa + w_q) >> FRAC_BITS);

    // side offsets and limit check
    assign w_dfe = AW'(r_degf);
    assign w_dre = AW'(r_degr);
    assign w_foe = AW'(r_front_off);
    assign w_roe = AW'(r_rear_off);
    assign w_fa  = r_side ? (w_dfe - w_foe) : (w_foe - w_dfe);
    assign w_ra  = r_side ? (w_roe - w_dre) : (w_dre - w_roe);
    assign w_frej = !r_fail && ((w_fa < A_MIN) || (w_fa > A_MAX));
    assign w_rrej = !r_fail && ((w_ra < A_MIN) || (w_ra > A_MAX));
    assign w_hf_new = (!r_fail && !w_frej) ? w_fa[AGW-1:0] : r_hf[r_side];
    assign w_hr_new = (!r_fail && !w_rrej) ? w_ra[AGW-1:0] : r_hr[r_side];

    // control-side registers: config, held angles, multiplier busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= fbik_pkg::RST_UPPER_LEN;
            r_lower     <= fbik_pkg::RST_LOWER_LEN;
            r_spacing   <= fbik_pkg::RST_JOINT_SPACING;
            r_front_off <= fbik_pkg::RST_FRONT_OFFSET;
            r_rear_off  <= fbik_pkg::RST_REAR_OFFSET;
            r_hf[0]     <= '0;
            r_hf[1]     <= '0;
            r_hr[0]     <= '0;
            r_hr[1]     <= '0;
            r_mbusy     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fbik_pkg::CFG_UPPER_LEN:     r_upper     <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_LOWER_LEN:     r_lower     <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_JOINT_SPACING: r_spacing   <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_FRONT_OFFSET:  r_front_off <= i_cfg_wdata;
                    fbik_pkg::CFG_REAR_OFFSET:   r_rear_off  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_hf[r_side] <= w_hf_new;
                r_hr[r_side] <= w_hr_new;
            end
            if (i_cmd.mul_go) begin
                r_mbusy <= 1'b1;
            end else if (w_mdone) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_side  <= i_is_left;
            r_x     <= i_x;
            r_y     <= i_y;
            r_joint <= 1'b0;
            r_fail  <= 1'b0;
        end
        if (i_cmd.next_joint) begin
            r_joint <= 1'b1;
        end
        if (i_cmd.mark_fail) begin
            r_fail <= 1'b1;
        end

        // multiplier: result retires into its destination on the last pass
        if (w_mdone) begin
            unique case (r_msel)
                fbik_pkg::MS_PX:  r_s <= w_mres;
                fbik_pkg::MS_PY: begin
                    r_ysq <= w_mres;
                    r_s   <= r_s + w_mres;
                end
                fbik_pkg::MS_L2S: r_m2  <= w_mres << 2;
                fbik_pkg::MS_AN:  r_an2 <= w_mres;
                default: ;
            endcase
        end
        if (i_cmd.mul_go) begin
            r_acc  <= '0;
            r_mcnt <= 2'd0;
            r_msel <= i_cmd.msel;
            unique case (i_cmd.msel)
                fbik_pkg::MS_PX: begin
                    r_ma <= w_px;
                    r_mb <= w_px;
                    r_px <= w_px;
                end
                fbik_pkg::MS_PY: begin
                    r_ma <= w_ye;
                    r_mb <= w_ye;
                end
                fbik_pkg::MS_L2S: begin
                    r_ma <= {{(DW-16){1'b0}}, w_l2};
                    r_mb <= r_s;
                end
                fbik_pkg::MS_AN: begin
                    r_ma <= w_an;
                    r_mb <= w_an;
                    r_n  <= w_n;
                end
                default: ;
            endcase
        end else if (r_mbusy) begin
            r_acc  <= w_mres;
            r_ma   <= r_ma << 16;
            r_mb   <= r_mb >> 16;
            r_mcnt <= r_mcnt + 2'd1;
        end

        // vector normalization
        if (i_cmd.vec_a) begin
            r_vx    <= r_px;
            r_vysq  <= r_ysq;
            r_vm    <= r_s;
            r_k     <= '0;
            r_phase <= 1'b0;
        end else if (i_cmd.vec_b) begin
            r_vx    <= r_n;
            r_vysq  <= r_m2 - r_an2;
            r_vm    <= r_m2;
            r_k     <= '0;
            r_phase <= 1'b1;
        end else if (i_cmd.norm_step) begin
            r_vx   <= r_vx <<< 1;
            r_vysq <= r_vysq << 2;
            r_vm   <= r_vm << 2;
            r_k    <= r_k + 5'd1;
        end

        // restoring square root, one result bit per cycle
        if (i_cmd.sqrt_init) begin
            r_sv <= r_vysq;
            r_sr <= '0;
            r_it <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= w_strial) begin
                r_sv <= r_sv - w_strial;
                r_sr <= (r_sr >> 1) + w_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_it <= r_it + 5'd1;
        end

        // vectoring CORDIC, one step per cycle
        if (i_cmd.cord_init) begin
            r_it <= '0;
            if (r_vx[DW-1]) begin
                r_cx <= r_sr;
                r_cy <= -r_vx;
                r_cz <= Z_90;
            end else begin
                r_cx <= r_vx;
                r_cy <= r_sr;
                r_cz <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_cy > 0) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + DW'(fbik_pkg::ATAN_TAB[r_it]);
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - DW'(fbik_pkg::ATAN_TAB[r_it]);
            end
            r_it <= r_it + 5'd1;
        end
        if (i_cmd.cord_end) begin
            if (!r_phase) begin
                r_qa <= w_q;
            end else if (r_joint) begin
                r_degr <= w_deg;
            end else begin
                r_degf <= w_deg;
            end
        end

        if (i_cmd.finish) begin
            r_o_side <= r_side;
            r_o_fa   <= w_hf_new;
            r_o_ra   <= w_hr_new;
            r_o_fp   <= pulse_of(w_hf_new);
            r_o_rp   <= pulse_of(w_hr_new);
            r_o_unr  <= r_fail;
            r_o_frej <= w_frej;
            r_o_rrej <= w_rrej;
        end
    end

    assign o_stat.mul_busy   = r_mbusy;
    assign o_stat.mul_done   = w_mdone;
    assign o_stat.fail       = (r_s == '0) || (r_m2 == '0) || (r_an2 > r_m2);
    assign o_stat.norm_more  = (r_k != 5'(fbik_pkg::NORM_K_MAX)) && (r_vm[DW-3:DW-6] == 4'd0);
    assign o_stat.sqrt_last  = (r_it == 5'(fbik_pkg::SQRT_STEPS - 1));
    assign o_stat.cord_last  = (r_it == 5'(fbik_pkg::CORDIC_STEPS - 1));
    assign o_stat.phase_b    = r_phase;
    assign o_stat.joint_rear = r_joint;

    assign o_side           = r_o_side;
    assign o_front_deg      = r_o_fa;
    assign o_rear_deg       = r_o_ra;
    assign o_front_pulse_us = r_o_fp;
    assign o_rear_pulse_us  = r_o_rp;
    assign o_unreachable    = r_o_unr;
    assign o_front_rejected = r_o_frej;
    assign o_rear_rejected  = r_o_rrej;

endmodule

[hw/rtl/five_bar_leg_ik_servo.sv]
// Throughput: one item at a time, the next input taken in the cycle after the result is
// registered; each joint costs four 4-pass multiplies, then two angle solves of up to
// NORM_K_MAX normalize, 32 square-root and 23 CORDIC steps, one per cycle.
// Reset: config registers return to 40/24/21/135/135, all held angles to 0 degrees,
// and the controller to idle with no result pending.
module five_bar_leg_ik_servo #(
    parameter int COORD_WIDTH = 8,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fbik_in_if.sink                             i_in,
    fbik_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbik_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    fbik_pkg::t_cmd  w_cmd;
    fbik_pkg::t_stat w_stat;

    fbik_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    fbik_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_is_left        (i_in.is_left),
        .i_x              (i_in.x),
        .i_y              (i_in.y),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_side           (o_out.side),
        .o_front_deg      (o_out.front_deg),
        .o_rear_deg       (o_out.rear_deg),
        .o_front_pulse_us (o_out.front_pulse_us),
        .o_rear_pulse_us  (o_out.rear_pulse_us),
        .o_unreachable    (o_out.unreachable),
        .o_front_rejected (o_out.front_rejected),
        .o_rear_rejected  (o_out.rear_rejected)
    );

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out.valid)
        else $error("result not presented after finish");

    a_load_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_in |-> !w_stat.mul_busy)
        else $error("new item taken while multiplier busy");

    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_go |=> !w_stat.mul_done)
        else $error("multiply retired too early");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.front_deg >= -8'sd90 && o_out.front_deg <= 8'sd90
                         && o_out.rear_deg >= -8'sd90 && o_out.rear_deg <= 8'sd90))
        else $error("held angle out of servo range");

endmodule

[tb/sv/fbik_checker.sv]
module fbik_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fbik_in_if                               i_in,
    fbik_out_if                              i_out,
    input  logic                             i_cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fbik_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                               o_fails,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              side;
        logic signed [7:0] front_deg;
        logic signed [7:0] rear_deg;
        logic [11:0]       front_pulse_us;
        logic [11:0]       rear_pulse_us;
        logic              unreachable;
        logic              front_rejected;
        logic              rear_rejected;
    } t_servo_cmd;

    t_servo_cmd        servo_q[$];
    logic [7:0]        upper_len, lower_len, joint_spacing;
    logic [8:0]        front_off, rear_off;
    logic signed [7:0] held[4];

    assign o_pending = servo_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // direction of (xc, sqrt(ysq)) in Q8 degrees, 0..180
    function automatic longint unsigned dir_q8(longint xc, longint unsigned ysq,
                                               longint unsigned m2);
        int      k;
        longint  vx, vy, z, dx, dy, t;
        k = 0;
        while (k < fbik_pkg::NORM_K_MAX && (m2 << (2 * k + 2)) < (64'd1 << 60)) k++;
        vx = xc * (longint'(1) << k);
        vy = longint'(int_sqrt(ysq << (2 * k)));
        z  = 0;
        if (vx < 0) begin
            t  = vx;
            vx = vy;
            vy = -t;
            z  = longint'(90) <<< fbik_pkg::TAB_BITS;
        end
        for (int i = 0; i < fbik_pkg::CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + longint'({42'd0, fbik_pkg::ATAN_TAB[i]});
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - longint'({42'd0, fbik_pkg::ATAN_TAB[i]});
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(180) <<< fbik_pkg::TAB_BITS)) z = longint'(180) <<< fbik_pkg::TAB_BITS;
        return longint'(z) >> (fbik_pkg::TAB_BITS - 8);
    endfunction

    function automatic bit joint_deg(longint px, longint py, output longint unsigned deg);
        longint unsigned s, m2, an, qa, qb;
        longint          l, u, n;
        deg = 0;
        s  = px * px + py * py;
        l  = lower_len;
        u  = upper_len;
        m2 = 4 * l * l * s;
        if (s == 0 || m2 == 0) return 0;
        n  = l * l + longint'(s) - u * u;
        an = (n < 0) ? -n : n;
        if (an * an > m2) return 0;
        qa = dir_q8(px, py * py, s);
        qb = dir_q8(n, m2 - an * an, m2);
        deg = (qa + qb) >> 8;
        return 1;
    endfunction

    function automatic logic [11:0] pulse_width(logic signed [7:0] a);
        return 12'((int'(a) + 90) * 2000 / 180 + 500);
    endfunction

    function automatic t_servo_cmd solve_target(logic left, logic signed [7:0] tx,
                                                logic signed [7:0] ty);
        t_servo_cmd      r;
        longint unsigned df, dr;
        longint          fa, ra;
        bit              ok_f, ok_r;
        r = '0;
        ok_f = joint_deg(tx, ty, df);
        ok_r = joint_deg(longint'(joint_spacing) - tx, ty, dr);
        if (!ok_f || !ok_r) begin
            r.unreachable = 1'b1;
        end else begin
            if (left) begin
                fa = longint'(df) - front_off;
                ra = longint'(rear_off) - longint'(dr);
            end else begin
                fa = longint'(front_off) - longint'(df);
                ra = longint'(dr) - rear_off;
            end
            if (fa < fbik_pkg::MIN_DEG || fa > fbik_pkg::MAX_DEG) r.front_rejected = 1'b1;
            else held[left * 2] = 8'(fa);
            if (ra < fbik_pkg::MIN_DEG || ra > fbik_pkg::MAX_DEG) r.rear_rejected = 1'b1;
            else held[left * 2 + 1] = 8'(ra);
        end
        r.side           = left;
        r.front_deg      = held[left * 2];
        r.rear_deg       = held[left * 2 + 1];
        r.front_pulse_us = pulse_width(r.front_deg);
        r.rear_pulse_us  = pulse_width(r.rear_deg);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_servo_cmd got, want;
        if (!i_rst_n) begin
            upper_len     <= fbik_pkg::RST_UPPER_LEN;
            lower_len     <= fbik_pkg::RST_LOWER_LEN;
            joint_spacing <= fbik_pkg::RST_JOINT_SPACING;
            front_off     <= fbik_pkg::RST_FRONT_OFFSET;
            rear_off      <= fbik_pkg::RST_REAR_OFFSET;
            for (int i = 0; i < 4; i++) held[i] = '0;
            servo_q.delete();
            o_fails <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fbik_pkg::CFG_UPPER_LEN:     upper_len     <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_LOWER_LEN:     lower_len     <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_JOINT_SPACING: joint_spacing <= i_cfg_wdata[7:0];
                    fbik_pkg::CFG_FRONT_OFFSET:  front_off     <= i_cfg_wdata;
                    fbik_pkg::CFG_REAR_OFFSET:   rear_off      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.side, i_out.front_deg, i_out.rear_deg,
                        i_out.front_pulse_us, i_out.rear_pulse_us, i_out.unreachable,
                        i_out.front_rejected, i_out.rear_rejected};
                if (servo_q.size() == 0) begin
                    $display("%0t: result with none expected: %p", $realtime, got);
                    o_fails <= o_fails + 1;
                end else begin
                    want = servo_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                servo_q.push_back(solve_target(i_in.is_left, i_in.x, i_in.y));
        end
    end
endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 1500;
    // indexes with no register behind them
    localparam logic [fbik_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [fbik_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [fbik_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [fbik_pkg::CFG_DATA_W-1:0] cfg_wdata;
    int                              fails, pending;
    int                              src_idle, snk_idle;
    logic                            hold_req, hold_done;
    int                              hold_left, quiet_cycles;
    logic [7:0]                      cur_upper, cur_lower, cur_spacing;

    fbik_in_if  tgt_if();
    fbik_out_if srv_if();

    five_bar_leg_ik_servo uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tgt_if),
        .o_out       (srv_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    fbik_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tgt_if),
        .i_out       (srv_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            srv_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            srv_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            srv_if.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
            hold_done    <= 1'b1;
        end else begin
            srv_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tgt_if.valid && tgt_if.ready) || (srv_if.valid && srv_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic set_config(logic [7:0] up, logic [7:0] lo, logic [7:0] sp,
                              logic [8:0] fo, logic [8:0] ro);
        logic [fbik_pkg::CFG_IDX_W-1:0]  idx[7];
        logic [fbik_pkg::CFG_DATA_W-1:0] val[7];
        idx = '{fbik_pkg::CFG_UPPER_LEN, fbik_pkg::CFG_LOWER_LEN, fbik_pkg::CFG_JOINT_SPACING,
                fbik_pkg::CFG_FRONT_OFFSET, fbik_pkg::CFG_REAR_OFFSET, CFG_SPARE_LO,
                CFG_SPARE_HI};
        // writes to unused indexes must be ignored
        val = '{{1'b0, up}, {1'b0, lo}, {1'b0, sp}, fo, ro, 9'h1ff, 9'h0aa};
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= idx[i];
            cfg_wdata <= val[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_upper   = up;
        cur_lower   = lo;
        cur_spacing = sp;
    endtask

    // leaves valid high; the next call either idles or replaces the data
    task automatic send_target(logic left, logic signed [7:0] tx, logic signed [7:0] ty);
        if ($urandom_range(99) < src_idle) begin
            tgt_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        tgt_if.valid   <= 1'b1;
        tgt_if.is_left <= left;
        tgt_if.x       <= tx;
        tgt_if.y       <= ty;
        do @(negedge i_clk); while (!tgt_if.ready);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        tgt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_random();
        int r, cx;
        r = cur_upper + cur_lower;
        if (r > 127) r = 127;
        if ($urandom_range(99) < 75) begin
            // mostly inside the working area of the current linkage
            cx = int'(cur_spacing) / 2 + $urandom_range(0, 2 * r) - r;
            if (cx > 127) cx = 127;
            if (cx < -128) cx = -128;
            send_target(1'($urandom_range(1)), 8'(cx), 8'($urandom_range(0, 2 * r) - r));
        end else begin
            send_target(1'($urandom_range(1)), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [7:0] ups[6], los[6], sps[6];
        logic [8:0] fos[6], ros[6];
        ups = '{8'd40,  8'd255, 8'd1,   8'd60,  8'd30,  8'd35};
        los = '{8'd24,  8'd255, 8'd1,   8'd45,  8'd50,  8'd35};
        sps = '{8'd21,  8'd0,   8'd255, 8'd30,  8'd10,  8'd20};
        fos = '{9'd135, 9'd0,   9'd359, 9'd90,  9'd200, 9'd256};
        ros = '{9'd135, 9'd359, 9'd0,   9'd180, 9'd100, 9'd150};

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        tgt_if.valid   = 1'b0;
        tgt_if.is_left = 1'b0;
        tgt_if.x       = '0;
        tgt_if.y       = '0;
        hold_req       = 1'b0;
        src_idle       = 0;
        snk_idle       = 0;
        cur_upper      = fbik_pkg::RST_UPPER_LEN;
        cur_lower      = fbik_pkg::RST_LOWER_LEN;
        cur_spacing    = fbik_pkg::RST_JOINT_SPACING;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry, axis points, reach limits, field extremes
        send_target(1'b0, 8'sd10, -8'sd40);
        send_target(1'b1, 8'sd10, -8'sd40);
        send_target(1'b0, 8'sd0, 8'sd0);
        send_target(1'b1, 8'sd21, 8'sd0);
        send_target(1'b0, 8'sd127, 8'sd127);
        send_target(1'b1, -8'sd128, -8'sd128);
        send_target(1'b0, -8'sd128, 8'sd127);
        send_target(1'b1, 8'sd127, -8'sd128);
        send_target(1'b0, 8'sd0, -8'sd30);
        send_target(1'b1, -8'sd20, 8'sd35);
        send_target(1'b0, 8'sd30, 8'sd50);
        send_target(1'b1, -8'sd1, -8'sd1);
        send_target(1'b0, 8'sd5, -8'sd60);
        send_target(1'b1, 8'sd40, -8'sd20);
        wait_idle();
        // zero lower link: everything unreachable
        set_config(8'd40, 8'd0, 8'd21, 9'd135, 9'd135);
        send_target(1'b0, 8'sd10, -8'sd40);
        send_target(1'b1, 8'sd10, -8'sd40);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            set_config(ups[ph], los[ph], sps[ph], fos[ph], ros[ph]);
            src_idle = (ph < 2) ? 35 : (ph < 4) ? 53 : 0;
            snk_idle = (ph < 2) ? 53 : (ph < 4) ? 35 : 0;
            for (int n = 0; n < 130; n++) begin
                if (ph == 1 && n == 60) hold_req = 1'b1;
                send_random();
                if (ph == 1 && hold_done) hold_req = 1'b0;
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
